// ----- hdl/complex_arith_unit_core_assert.svh -----
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_CORE_ASSERT_SVH

// Check prop in the same cycle as cond.
`define CAU_ASSERT_NOW(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("cau assertion failed");

// Check prop in the cycle after cond.
`define CAU_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("cau assertion failed");

`endif

// ----- hdl/cau_pkg.sv -----
package cau_pkg;

   localparam int DataBits = 32;
   localparam int FuncBits = 2;
   localparam int WordBitsDefault = 32;
   localparam int FracBitsDefault = 16;

   typedef enum logic [FuncBits-1:0] {
      FUNC_ADD,
      FUNC_SUB,
      FUNC_MUL,
      FUNC_DIV
   } func_type;

   typedef struct packed {
      logic is_div;
      logic dz;
      logic ov_re;
      logic ov_im;
      logic neg_re;
      logic neg_im;
   } flow_type;

endpackage

// ----- hdl/cau_req_if.sv -----
interface cau_req_if;
   import cau_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FuncBits-1:0]        func;
   logic signed [DataBits-1:0] a_re;
   logic signed [DataBits-1:0] a_im;
   logic signed [DataBits-1:0] b_re;
   logic signed [DataBits-1:0] b_im;

   modport source (output valid, func, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, func, a_re, a_im, b_re, b_im, output ready);

endinterface

// ----- hdl/cau_rsp_if.sv -----
interface cau_rsp_if;
   import cau_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DataBits-1:0] re_out;
   logic signed [DataBits-1:0] im_out;
   logic                       div_by_zero;
   logic                       overflow;

   modport source (output valid, re_out, im_out, div_by_zero, overflow, input ready);
   modport sink (input valid, re_out, im_out, div_by_zero, overflow, output ready);

endinterface

// ----- hdl/cau_front.sv -----
module cau_front #(
   parameter int WORD_BITS = cau_pkg::WordBitsDefault,
   parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   cau_req_if.sink                     req_bus,
   output logic                        down_valid,
   input  logic                        down_ready,
   output cau_pkg::flow_type           down_flow,
   output logic [WORD_BITS-1:0]        down_q_re,
   output logic [WORD_BITS-1:0]        down_q_im,
   output logic [2*WORD_BITS-1:0]      down_rem_re,
   output logic [2*WORD_BITS-1:0]      down_rem_im,
   output logic [WORD_BITS-1:0]        down_low_re,
   output logic [WORD_BITS-1:0]        down_low_im,
   output logic [2*WORD_BITS-1:0]      down_den
);
   import cau_pkg::*;

   localparam int W = WORD_BITS;
   localparam int F = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int NW = PW + F;

   function automatic logic [W:0] sat_word(input logic signed [PW:0] v);
      logic signed [PW:0] ext;
      ext = (PW+1)'(signed'(v[W-1:0]));
      if (ext == v) begin
         return {1'b0, v[W-1:0]};
      end else if (v[PW]) begin
         return {1'b1, 1'b1, (W-1)'(0)};
      end else begin
         return {1'b1, 1'b0, {(W-1){1'b1}}};
      end
   endfunction

   logic signed [W-1:0] ar, ai, br, bi;
   logic signed [W:0]   as_re_in, as_im_in;
   logic a_ready, b_ready, c_ready;

   assign ar = req_bus.a_re[W-1:0];
   assign ai = req_bus.a_im[W-1:0];
   assign br = req_bus.b_re[W-1:0];
   assign bi = req_bus.b_im[W-1:0];

   always_comb begin
      if (func_type'(req_bus.func) == FUNC_SUB) begin
         as_re_in = {ar[W-1], ar} - {br[W-1], br};
         as_im_in = {ai[W-1], ai} - {bi[W-1], bi};
      end else begin
         as_re_in = {ar[W-1], ar} + {br[W-1], br};
         as_im_in = {ai[W-1], ai} + {bi[W-1], bi};
      end
   end

   // stage A: products and add/sub results
   logic                 a_valid_ff;
   func_type             a_func_ff;
   logic signed [PW-1:0] a_prr_ff, a_pii_ff, a_pri_ff, a_pir_ff, a_srr_ff, a_sii_ff;
   logic signed [W:0]    a_as_re_ff, a_as_im_ff;

   assign a_ready = !a_valid_ff || b_ready;
   assign req_bus.ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_func_ff  <= func_type'(req_bus.func);
         a_prr_ff   <= ar * br;
         a_pii_ff   <= ai * bi;
         a_pri_ff   <= ar * bi;
         a_pir_ff   <= ai * br;
         a_srr_ff   <= br * br;
         a_sii_ff   <= bi * bi;
         a_as_re_ff <= as_re_in;
         a_as_im_ff <= as_im_in;
      end
   end

   // stage B: sums, scaling, saturation
   logic signed [PW:0] m_re, m_im, m_re_sh, m_im_sh, d_re, d_im;
   logic [W:0]         s_re, s_im;
   logic               b_valid_ff;
   flow_type           b_flow_ff, b_flow_in;
   logic [PW-1:0]      b_val_re_ff, b_val_re_in, b_val_im_ff, b_val_im_in;
   logic [PW-1:0]      b_den_ff, b_den_in;

   assign b_ready = !b_valid_ff || c_ready;

   always_comb begin
      m_re     = (PW+1)'(a_prr_ff) - (PW+1)'(a_pii_ff);
      m_im     = (PW+1)'(a_pri_ff) + (PW+1)'(a_pir_ff);
      m_re_sh  = m_re >>> F;
      m_im_sh  = m_im >>> F;
      d_re     = (PW+1)'(a_prr_ff) + (PW+1)'(a_pii_ff);
      d_im     = (PW+1)'(a_pir_ff) - (PW+1)'(a_pri_ff);
      b_den_in = a_srr_ff[PW-1:0] + a_sii_ff[PW-1:0];
      b_flow_in = '0;
      s_re = '0;
      s_im = '0;
      b_val_re_in = '0;
      b_val_im_in = '0;
      case (a_func_ff)
         FUNC_ADD, FUNC_SUB: begin
            s_re = sat_word((PW+1)'(a_as_re_ff));
            s_im = sat_word((PW+1)'(a_as_im_ff));
         end
         FUNC_MUL: begin
            s_re = sat_word(m_re_sh);
            s_im = sat_word(m_im_sh);
         end
         default: begin
            b_flow_in.is_div = 1'b1;
         end
      endcase
      if (b_flow_in.is_div) begin
         b_flow_in.neg_re = d_re[PW];
         b_flow_in.neg_im = d_im[PW];
         b_val_re_in = d_re[PW] ? PW'(-d_re) : d_re[PW-1:0];
         b_val_im_in = d_im[PW] ? PW'(-d_im) : d_im[PW-1:0];
      end else begin
         b_flow_in.ov_re = s_re[W];
         b_flow_in.ov_im = s_im[W];
         b_val_re_in = PW'(s_re[W-1:0]);
         b_val_im_in = PW'(s_im[W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         b_flow_ff   <= b_flow_in;
         b_val_re_ff <= b_val_re_in;
         b_val_im_ff <= b_val_im_in;
         b_den_ff    <= b_den_in;
      end
   end

   // stage C: shift numerators, range check, seed the divider
   logic [NW-1:0] n_re, n_im, h_re, h_im, den_x;
   logic          dz;
   logic          c_valid_ff;
   flow_type      c_flow_ff, c_flow_in;
   logic [W-1:0]  c_q_re_ff, c_q_re_in, c_q_im_ff, c_q_im_in;
   logic [W-1:0]  c_low_re_ff, c_low_re_in, c_low_im_ff, c_low_im_in;
   logic [PW-1:0] c_rem_re_ff, c_rem_re_in, c_rem_im_ff, c_rem_im_in;
   logic [PW-1:0] c_den_ff;

   assign c_ready = !c_valid_ff || down_ready;

   always_comb begin
      n_re  = NW'(b_val_re_ff) << F;
      n_im  = NW'(b_val_im_ff) << F;
      h_re  = n_re >> W;
      h_im  = n_im >> W;
      den_x = NW'(b_den_ff);
      dz    = b_den_ff == '0;
      c_flow_in = b_flow_ff;
      if (b_flow_ff.is_div) begin
         c_flow_in.dz    = dz;
         c_flow_in.ov_re = !dz && (h_re >= den_x);
         c_flow_in.ov_im = !dz && (h_im >= den_x);
         c_q_re_in   = '0;
         c_q_im_in   = '0;
         c_rem_re_in = h_re[PW-1:0];
         c_rem_im_in = h_im[PW-1:0];
         c_low_re_in = n_re[W-1:0];
         c_low_im_in = n_im[W-1:0];
      end else begin
         c_q_re_in   = b_val_re_ff[W-1:0];
         c_q_im_in   = b_val_im_ff[W-1:0];
         c_rem_re_in = '0;
         c_rem_im_in = '0;
         c_low_re_in = '0;
         c_low_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready) begin
         c_flow_ff   <= c_flow_in;
         c_q_re_ff   <= c_q_re_in;
         c_q_im_ff   <= c_q_im_in;
         c_rem_re_ff <= c_rem_re_in;
         c_rem_im_ff <= c_rem_im_in;
         c_low_re_ff <= c_low_re_in;
         c_low_im_ff <= c_low_im_in;
         c_den_ff    <= b_den_ff;
      end
   end

   assign down_valid  = c_valid_ff;
   assign down_flow   = c_flow_ff;
   assign down_q_re   = c_q_re_ff;
   assign down_q_im   = c_q_im_ff;
   assign down_rem_re = c_rem_re_ff;
   assign down_rem_im = c_rem_im_ff;
   assign down_low_re = c_low_re_ff;
   assign down_low_im = c_low_im_ff;
   assign down_den    = c_den_ff;

endmodule

// ----- hdl/cau_div_cell.sv -----
`include "complex_arith_unit_core_assert.svh"

module cau_div_cell #(
   parameter int WORD_BITS = cau_pkg::WordBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  cau_pkg::flow_type      up_flow,
   input  logic [WORD_BITS-1:0]   up_q_re,
   input  logic [WORD_BITS-1:0]   up_q_im,
   input  logic [2*WORD_BITS-1:0] up_rem_re,
   input  logic [2*WORD_BITS-1:0] up_rem_im,
   input  logic [WORD_BITS-1:0]   up_low_re,
   input  logic [WORD_BITS-1:0]   up_low_im,
   input  logic [2*WORD_BITS-1:0] up_den,
   output logic                   down_valid,
   input  logic                   down_ready,
   output cau_pkg::flow_type      down_flow,
   output logic [WORD_BITS-1:0]   down_q_re,
   output logic [WORD_BITS-1:0]   down_q_im,
   output logic [2*WORD_BITS-1:0] down_rem_re,
   output logic [2*WORD_BITS-1:0] down_rem_im,
   output logic [WORD_BITS-1:0]   down_low_re,
   output logic [WORD_BITS-1:0]   down_low_im,
   output logic [2*WORD_BITS-1:0] down_den
);
   import cau_pkg::*;

   localparam int W = WORD_BITS;
   localparam int PW = 2 * W;

   // one restoring step: {quotient bit, new remainder}
   function automatic logic [PW:0] div_step(input logic [PW-1:0] rem,
                                            input logic bit_in,
                                            input logic [PW-1:0] d);
      logic [PW:0] r2;
      logic [PW:0] diff;
      logic        ge;
      r2   = {rem, bit_in};
      diff = r2 - {1'b0, d};
      ge   = r2 >= {1'b0, d};
      return {ge, ge ? diff[PW-1:0] : r2[PW-1:0]};
   endfunction

   logic          valid_ff;
   flow_type      flow_ff;
   logic [W-1:0]  q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic [W-1:0]  low_re_ff, low_re_in, low_im_ff, low_im_in;
   logic [PW-1:0] rem_re_ff, rem_re_in, rem_im_ff, rem_im_in;
   logic [PW-1:0] den_ff;
   logic [PW:0]   st_re, st_im;

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      st_re = div_step(up_rem_re, up_low_re[W-1], up_den);
      st_im = div_step(up_rem_im, up_low_im[W-1], up_den);
      if (up_flow.is_div) begin
         q_re_in   = {up_q_re[W-2:0], st_re[PW]};
         q_im_in   = {up_q_im[W-2:0], st_im[PW]};
         rem_re_in = st_re[PW-1:0];
         rem_im_in = st_im[PW-1:0];
         low_re_in = up_low_re << 1;
         low_im_in = up_low_im << 1;
      end else begin
         q_re_in   = up_q_re;
         q_im_in   = up_q_im;
         rem_re_in = up_rem_re;
         rem_im_in = up_rem_im;
         low_re_in = up_low_re;
         low_im_in = up_low_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         flow_ff   <= up_flow;
         q_re_ff   <= q_re_in;
         q_im_ff   <= q_im_in;
         rem_re_ff <= rem_re_in;
         rem_im_ff <= rem_im_in;
         low_re_ff <= low_re_in;
         low_im_ff <= low_im_in;
         den_ff    <= up_den;
      end
   end

   assign down_valid  = valid_ff;
   assign down_flow   = flow_ff;
   assign down_q_re   = q_re_ff;
   assign down_q_im   = q_im_ff;
   assign down_rem_re = rem_re_ff;
   assign down_rem_im = rem_im_ff;
   assign down_low_re = low_re_ff;
   assign down_low_im = low_im_ff;
   assign down_den    = den_ff;

   `CAU_ASSERT_NOW(rem_below_den_a, valid_ff && flow_ff.is_div && !flow_ff.dz && !flow_ff.ov_re, rem_re_ff < den_ff)
   `CAU_ASSERT_NOW(pass_rem_zero_a, valid_ff && !flow_ff.is_div, rem_re_ff == '0 && rem_im_ff == '0)
   `CAU_ASSERT_NEXT(stall_hold_a, valid_ff && !down_ready, valid_ff && $stable(q_re_ff) && $stable(q_im_ff))

endmodule

// ----- hdl/cau_back.sv -----
`include "complex_arith_unit_core_assert.svh"

module cau_back #(
   parameter int WORD_BITS = cau_pkg::WordBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  cau_pkg::flow_type    up_flow,
   input  logic [WORD_BITS-1:0] up_q_re,
   input  logic [WORD_BITS-1:0] up_q_im,
   cau_rsp_if.source            rsp_bus
);
   import cau_pkg::*;

   localparam int W = WORD_BITS;
   localparam logic [W-1:0] WordMax = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WordMin = {1'b1, (W-1)'(0)};
   localparam logic signed [DataBits-1:0] OutMax = DataBits'(signed'(WordMax));
   localparam logic signed [DataBits-1:0] OutMin = DataBits'(signed'(WordMin));

   // apply sign and clamp a quotient magnitude: {overflow, word}
   function automatic logic [W:0] finish(input logic [W-1:0] q, input logic neg,
                                         input logic ov);
      logic [W-1:0] lim;
      lim = neg ? WordMin : WordMax;
      if (ov || (q > lim)) begin
         return {1'b1, lim};
      end else begin
         return {1'b0, neg ? W'(-q) : q};
      end
   endfunction

   logic                       valid_ff;
   logic signed [DataBits-1:0] re_ff, re_in, im_ff, im_in;
   logic                       dz_ff, dz_in, ov_ff, ov_in;
   logic [W:0]                 f_re, f_im;

   assign up_ready = !valid_ff || rsp_bus.ready;

   always_comb begin
      f_re  = finish(up_q_re, up_flow.neg_re, up_flow.ov_re);
      f_im  = finish(up_q_im, up_flow.neg_im, up_flow.ov_im);
      dz_in = 1'b0;
      if (!up_flow.is_div) begin
         re_in = DataBits'(signed'(up_q_re));
         im_in = DataBits'(signed'(up_q_im));
         ov_in = up_flow.ov_re || up_flow.ov_im;
      end else if (up_flow.dz) begin
         re_in = '0;
         im_in = '0;
         ov_in = 1'b0;
         dz_in = 1'b1;
      end else begin
         re_in = DataBits'(signed'(f_re[W-1:0]));
         im_in = DataBits'(signed'(f_im[W-1:0]));
         ov_in = f_re[W] || f_im[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         re_ff <= re_in;
         im_ff <= im_in;
         dz_ff <= dz_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.re_out      = re_ff;
   assign rsp_bus.im_out      = im_ff;
   assign rsp_bus.div_by_zero = dz_ff;
   assign rsp_bus.overflow    = ov_ff;

   `CAU_ASSERT_NOW(dz_zero_a, valid_ff && dz_ff, re_ff == '0 && im_ff == '0 && !ov_ff)
   `CAU_ASSERT_NOW(ov_rail_a, valid_ff && ov_ff, re_ff == OutMax || re_ff == OutMin || im_ff == OutMax || im_ff == OutMin)

endmodule

// ----- hdl/complex_arith_unit_core.sv -----
// Channel  Dir  Handshake     Payload
// req_bus  in   valid/ready   func, a_re, a_im, b_re, b_im
// rsp_bus  out  valid/ready   re_out, im_out, div_by_zero, overflow
//
// One transaction per cycle unless rsp_bus stalls; every operation passes through all stages.
// The divider row makes one quotient bit per cell, WORD_BITS cells.
// Three front stages (products, sums, divider seed), one output register.
// Each stage stalls only when full and its successor is stalled.
// Synchronous reset clears the valid bits only.
module complex_arith_unit_core #(
   parameter int WORD_BITS = cau_pkg::WordBitsDefault,
   parameter int FRAC_BITS = cau_pkg::FracBitsDefault
) (
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_bus,
   cau_rsp_if.source  rsp_bus
);
   import cau_pkg::*;

   localparam int W = WORD_BITS;
   localparam int PW = 2 * W;

   logic          valid_c [W+1];
   logic          ready_c [W+1];
   flow_type      flow_c  [W+1];
   logic [W-1:0]  q_re_c  [W+1];
   logic [W-1:0]  q_im_c  [W+1];
   logic [PW-1:0] rem_re_c[W+1];
   logic [PW-1:0] rem_im_c[W+1];
   logic [W-1:0]  low_re_c[W+1];
   logic [W-1:0]  low_im_c[W+1];
   logic [PW-1:0] den_c   [W+1];

   cau_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .down_valid (valid_c[0]),
      .down_ready (ready_c[0]),
      .down_flow  (flow_c[0]),
      .down_q_re  (q_re_c[0]),
      .down_q_im  (q_im_c[0]),
      .down_rem_re(rem_re_c[0]),
      .down_rem_im(rem_im_c[0]),
      .down_low_re(low_re_c[0]),
      .down_low_im(low_im_c[0]),
      .down_den   (den_c[0])
   );

   for (genvar k = 0; k < W; k++) begin : g_cell
      cau_div_cell #(.WORD_BITS(WORD_BITS)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_c[k]),
         .up_ready   (ready_c[k]),
         .up_flow    (flow_c[k]),
         .up_q_re    (q_re_c[k]),
         .up_q_im    (q_im_c[k]),
         .up_rem_re  (rem_re_c[k]),
         .up_rem_im  (rem_im_c[k]),
         .up_low_re  (low_re_c[k]),
         .up_low_im  (low_im_c[k]),
         .up_den     (den_c[k]),
         .down_valid (valid_c[k+1]),
         .down_ready (ready_c[k+1]),
         .down_flow  (flow_c[k+1]),
         .down_q_re  (q_re_c[k+1]),
         .down_q_im  (q_im_c[k+1]),
         .down_rem_re(rem_re_c[k+1]),
         .down_rem_im(rem_im_c[k+1]),
         .down_low_re(low_re_c[k+1]),
         .down_low_im(low_im_c[k+1]),
         .down_den   (den_c[k+1])
      );
   end

   cau_back #(.WORD_BITS(WORD_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .up_valid(valid_c[W]),
      .up_ready(ready_c[W]),
      .up_flow (flow_c[W]),
      .up_q_re (q_re_c[W]),
      .up_q_im (q_im_c[W]),
      .rsp_bus (rsp_bus)
   );

endmodule
